/* rtl/isd_pkg.sv */
// ----------------------------------------------------------------------------
// isd_pkg: shared types and constants of the image stream deframer
// geometry of the three streams, command format between the header parser
// and the pairing back end, and the layout of one result beat
// ----------------------------------------------------------------------------
`default_nettype none

package isd_pkg;

    // image geometry per stream
    localparam int unsigned COLOR_ROWS         = 1080;
    localparam int unsigned COLOR_ROW_BYTES    = 5760;
    localparam int unsigned DEPTH_ROWS         = 424;
    localparam int unsigned DEPTH_ROW_BYTES    = 1024;
    localparam int unsigned INFRARED_ROWS      = 424;
    localparam int unsigned INFRARED_ROW_BYTES = 512;

    localparam int ROW_W = 11;
    localparam int COL_W = 13;
    localparam int LEN_W = 32;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNATURE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_CODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INFRARED_CODE = 2'd3;

    // command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    typedef enum logic [1:0] {
        KIND_COLOR    = 2'd0,
        KIND_DEPTH    = 2'd1,
        KIND_INFRARED = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,  // type byte seen, latch the fill bank
        OP_FNUM      = 3'd1,  // frame number byte
        OP_PAYLOAD   = 3'd2,  // payload byte with position
        OP_EMPTY_END = 3'd3,  // header of a zero length frame completed
        OP_RELEASE   = 3'd4   // consumer released the read pair
    } op_t;

    typedef struct packed {
        op_t              op;
        kind_t            kind;
        logic [7:0]       data;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } cmd_t;

    typedef struct packed {
        logic             write_valid;
        kind_t            stream_kind;
        logic             write_bank;
        logic [ROW_W-1:0] pixel_row;
        logic [COL_W-1:0] byte_column;
        logic [7:0]       pixel_byte;
        logic             frame_end;
        logic             pair_ready;
        logic             pair_color_bank;
        logic             pair_depth_bank;
        logic             frame_lost;
    } res_t;

endpackage

`default_nettype wire

/* rtl/isd_front.sv */
// ----------------------------------------------------------------------------
// isd_front: header parser and payload position tracker
// holds the configuration registers, walks the 8-byte header, counts the
// payload down and issues one command per beat that matters to the back end
// ----------------------------------------------------------------------------
`default_nettype none

module isd_front
    import isd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_action,
    input  wire logic [7:0]           in_data,
    output logic                      in_ready,
    output logic                      cmd_valid,
    output cmd_t                      cmd,
    input  wire logic                 cmd_ready
);

    localparam logic [2:0] HP_SIG0 = 3'd0;
    localparam logic [2:0] HP_TYPE = 3'd1;
    localparam logic [2:0] HP_SIG1 = 3'd2;
    localparam logic [2:0] HP_FNUM = 3'd3;
    localparam logic [2:0] HP_LEN0 = 3'd4;
    localparam logic [2:0] HP_LEN1 = 3'd5;
    localparam logic [2:0] HP_LEN2 = 3'd6;
    localparam logic [2:0] HP_LEN3 = 3'd7;

    logic [7:0]       sig_reg, color_code_reg, depth_code_reg, ir_code_reg;
    logic [2:0]       hdr_pos_reg, hdr_pos_next;
    logic             in_payload_reg, in_payload_next;
    kind_t            stream_reg, stream_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic             accept, emit, hdr_ok;
    logic [ROW_W:0]   row_inc, rows_lim;
    logic [COL_W:0]   col_inc, cols_lim;
    logic [LEN_W-1:0] rem_dec, rem_full;

    assign in_ready  = cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = accept && emit;
    assign rem_full  = rem_reg | {in_data, 24'd0};
    assign rem_dec   = rem_reg - LEN_W'(1);
    assign row_inc   = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign col_inc   = {1'b0, col_reg} + (COL_W+1)'(1);

    always_comb begin
        case (stream_reg)
            KIND_COLOR: begin
                rows_lim = (ROW_W+1)'(COLOR_ROWS);
                cols_lim = (COL_W+1)'(COLOR_ROW_BYTES);
            end
            KIND_DEPTH: begin
                rows_lim = (ROW_W+1)'(DEPTH_ROWS);
                cols_lim = (COL_W+1)'(DEPTH_ROW_BYTES);
            end
            default: begin
                rows_lim = (ROW_W+1)'(INFRARED_ROWS);
                cols_lim = (COL_W+1)'(INFRARED_ROW_BYTES);
            end
        endcase
    end

    always_comb begin
        hdr_pos_next    = hdr_pos_reg;
        in_payload_next = in_payload_reg;
        stream_next     = stream_reg;
        rem_next        = rem_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        emit            = 1'b0;
        hdr_ok          = 1'b0;
        cmd.op          = OP_RELEASE;
        cmd.kind        = stream_reg;
        cmd.data        = in_data;
        cmd.row         = row_reg;
        cmd.col         = col_reg;
        cmd.last        = 1'b0;

        if (in_action) begin
            emit = 1'b1;
        end else if (in_payload_reg) begin
            emit     = 1'b1;
            cmd.op   = OP_PAYLOAD;
            cmd.last = (rem_dec == '0);
            rem_next = rem_dec;
            if (col_inc >= cols_lim) begin
                col_next = '0;
                row_next = (row_inc >= rows_lim) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
            if (rem_dec == '0) begin
                in_payload_next = 1'b0;
            end
        end else begin
            case (hdr_pos_reg)
                HP_SIG0, HP_SIG1: begin
                    hdr_ok = (in_data == sig_reg);
                end
                HP_TYPE: begin
                    // earlier stream wins when codes are equal
                    if (in_data == color_code_reg) begin
                        stream_next = KIND_COLOR;
                        hdr_ok      = 1'b1;
                    end else if (in_data == depth_code_reg) begin
                        stream_next = KIND_DEPTH;
                        hdr_ok      = 1'b1;
                    end else if (in_data == ir_code_reg) begin
                        stream_next = KIND_INFRARED;
                        hdr_ok      = 1'b1;
                    end
                    emit     = hdr_ok;
                    cmd.op   = OP_START;
                    cmd.kind = stream_next;
                end
                HP_FNUM: begin
                    hdr_ok = 1'b1;
                    emit   = 1'b1;
                    cmd.op = OP_FNUM;
                end
                HP_LEN0: begin
                    hdr_ok   = 1'b1;
                    rem_next = LEN_W'(in_data);
                end
                HP_LEN1: begin
                    hdr_ok   = 1'b1;
                    rem_next = rem_reg | {16'd0, in_data, 8'd0};
                end
                HP_LEN2: begin
                    hdr_ok   = 1'b1;
                    rem_next = rem_reg | {8'd0, in_data, 16'd0};
                end
                default: begin
                    hdr_ok   = 1'b1;
                    rem_next = rem_full;
                end
            endcase

            if (!hdr_ok) begin
                hdr_pos_next = HP_SIG0;
            end else if (hdr_pos_reg != HP_LEN3) begin
                hdr_pos_next = hdr_pos_reg + 3'd1;
            end else begin
                hdr_pos_next = HP_SIG0;
                row_next     = '0;
                col_next     = '0;
                if (rem_full == '0) begin
                    emit   = 1'b1;
                    cmd.op = OP_EMPTY_END;
                    cmd.row  = '0;
                    cmd.col  = '0;
                    cmd.data = '0;
                    cmd.last = 1'b1;
                end else begin
                    in_payload_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_reg        <= 8'd170;
            color_code_reg <= 8'd1;
            depth_code_reg <= 8'd2;
            ir_code_reg    <= 8'd3;
            hdr_pos_reg    <= HP_SIG0;
            in_payload_reg <= 1'b0;
            stream_reg     <= KIND_COLOR;
            rem_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SIGNATURE:     sig_reg        <= cfg_data;
                    REG_COLOR_CODE:    color_code_reg <= cfg_data;
                    REG_DEPTH_CODE:    depth_code_reg <= cfg_data;
                    REG_INFRARED_CODE: ir_code_reg    <= cfg_data;
                    default:           sig_reg        <= sig_reg;
                endcase
            end
            if (accept) begin
                hdr_pos_reg    <= hdr_pos_next;
                in_payload_reg <= in_payload_next;
                stream_reg     <= stream_next;
                rem_reg        <= rem_next;
                row_reg        <= row_next;
                col_reg        <= col_next;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/isd_queue.sv */
// ----------------------------------------------------------------------------
// isd_queue: short command queue between parser and back end
// lets the parser keep taking beats while the result side stalls
// ----------------------------------------------------------------------------
`default_nettype none

module isd_queue
    import isd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    input  wire cmd_t push_cmd,
    output logic      push_ready,
    output logic      pop_valid,
    output cmd_t      pop_cmd,
    input  wire logic pop_ready
);

    cmd_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push, pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        ptr_inc = (p == Q_PTR_W'(Q_DEPTH-1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/isd_back.sv */
// ----------------------------------------------------------------------------
// isd_back: bank bookkeeping, frame pairing and result register
// executes parser commands in order and drives the result beat
// ----------------------------------------------------------------------------
`default_nettype none

module isd_back
    import isd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_ready,
    output logic      res_valid,
    output res_t      res,
    input  wire logic res_ready
);

    logic       res_valid_reg, res_valid_next;
    res_t       res_reg, res_next;
    logic       cur_bank_reg, cur_bank_next;
    logic       c_fill_reg, c_fill_next, d_fill_reg, d_fill_next;
    logic       c_read_reg, c_read_next, d_read_reg, d_read_next;
    logic       c_armed_reg, c_armed_next, d_armed_reg, d_armed_next;
    logic [7:0] c_num_reg, c_num_next, d_num_reg, d_num_next;

    logic       out_free, has_res, pop, finish;
    logic       f_c_fill, f_d_fill, f_c_armed, f_d_armed, f_pair, f_lost, f_check;

    assign out_free  = !res_valid_reg || res_ready;
    assign has_res   = (cmd.op == OP_PAYLOAD) || (cmd.op == OP_EMPTY_END);
    assign cmd_ready = has_res ? out_free : 1'b1;
    assign pop       = cmd_valid && cmd_ready;
    assign finish    = has_res && cmd.last;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // frame end: flip fill bank of an armed stream, then pair or rearm
    always_comb begin
        f_c_fill  = c_fill_reg;
        f_d_fill  = d_fill_reg;
        f_c_armed = c_armed_reg;
        f_d_armed = d_armed_reg;
        f_pair    = 1'b0;
        f_lost    = 1'b0;
        f_check   = 1'b0;
        case (cmd.kind)
            KIND_COLOR: begin
                if (c_armed_reg) begin
                    f_c_fill  = !c_fill_reg;
                    f_c_armed = 1'b0;
                    f_check   = 1'b1;
                end
            end
            KIND_DEPTH: begin
                if (d_armed_reg) begin
                    f_d_fill  = !d_fill_reg;
                    f_d_armed = 1'b0;
                    f_check   = 1'b1;
                end
            end
            default: f_check = 1'b0;
        endcase
        if (f_check && !f_c_armed && !f_d_armed) begin
            if (c_num_reg == d_num_reg) begin
                f_pair = 1'b1;
            end else begin
                f_lost = 1'b1;
                // older frame gets its bank back
                if (c_num_reg > d_num_reg) begin
                    f_d_fill  = d_read_reg;
                    f_d_armed = 1'b1;
                end else begin
                    f_c_fill  = c_read_reg;
                    f_c_armed = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        cur_bank_next  = cur_bank_reg;
        c_fill_next    = c_fill_reg;
        d_fill_next    = d_fill_reg;
        c_read_next    = c_read_reg;
        d_read_next    = d_read_reg;
        c_armed_next   = c_armed_reg;
        d_armed_next   = d_armed_reg;
        c_num_next     = c_num_reg;
        d_num_next     = d_num_reg;

        if (pop) begin
            case (cmd.op)
                OP_START: begin
                    case (cmd.kind)
                        KIND_COLOR: cur_bank_next = c_fill_reg;
                        KIND_DEPTH: cur_bank_next = d_fill_reg;
                        default:    cur_bank_next = 1'b0;
                    endcase
                end
                OP_FNUM: begin
                    case (cmd.kind)
                        KIND_COLOR: c_num_next = cmd.data;
                        KIND_DEPTH: d_num_next = cmd.data;
                        default:    c_num_next = c_num_reg;
                    endcase
                end
                OP_RELEASE: begin
                    c_read_next  = !c_read_reg;
                    d_read_next  = !d_read_reg;
                    c_armed_next = 1'b1;
                    d_armed_next = 1'b1;
                end
                OP_PAYLOAD, OP_EMPTY_END: begin
                    res_valid_next           = 1'b1;
                    res_next.write_valid     = (cmd.op == OP_PAYLOAD);
                    res_next.stream_kind     = cmd.kind;
                    res_next.write_bank      = cur_bank_reg;
                    res_next.pixel_row       = cmd.row;
                    res_next.byte_column     = cmd.col;
                    res_next.pixel_byte      = cmd.data;
                    res_next.frame_end       = finish;
                    res_next.pair_ready      = finish && f_pair;
                    res_next.pair_color_bank = finish && f_pair && c_read_reg;
                    res_next.pair_depth_bank = finish && f_pair && d_read_reg;
                    res_next.frame_lost      = finish && f_lost;
                    if (finish) begin
                        c_fill_next  = f_c_fill;
                        d_fill_next  = f_d_fill;
                        c_armed_next = f_c_armed;
                        d_armed_next = f_d_armed;
                    end
                end
                default: res_next = res_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            cur_bank_reg  <= 1'b0;
            c_fill_reg    <= 1'b0;
            d_fill_reg    <= 1'b0;
            c_read_reg    <= 1'b0;
            d_read_reg    <= 1'b0;
            c_armed_reg   <= 1'b1;
            d_armed_reg   <= 1'b1;
            c_num_reg     <= '0;
            d_num_reg     <= '0;
        end else begin
            res_valid_reg <= res_valid_next;
            cur_bank_reg  <= cur_bank_next;
            c_fill_reg    <= c_fill_next;
            d_fill_reg    <= d_fill_next;
            c_read_reg    <= c_read_next;
            d_read_reg    <= d_read_next;
            c_armed_reg   <= c_armed_next;
            d_armed_reg   <= d_armed_next;
            c_num_reg     <= c_num_next;
            d_num_reg     <= d_num_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/image_stream_deframer.sv */
// ----------------------------------------------------------------------------
// image_stream_deframer: framed image byte stream to addressed pixel writes
// finds 8-byte frame headers in a byte stream and tags each payload byte with
// stream, double buffer bank, row and byte column; pairs color/depth frames
//
// usage
//   s_ channel: one beat per stream byte (s_tuser 0) or release (s_tuser 1)
//   m_ channel: one beat per payload byte, plus one for a zero length frame;
//     headers and releases give no result beat
//   cfg channel: signature and the three type codes, written while idle;
//     always ready
//   path: the command of an accepted beat is written into the command queue,
//     and its result beat is then held in the result register that drives m_
//   throughput: one beat per cycle on both sides while m_tready stays high;
//     each byte needs one pass through the parser counters and one through the
//     pairing logic
//   stall: when m_tready is low the result register holds, the two entry
//     command queue fills, and s_tready drops once it is full
//   reset: synchronous on aresetn low; control registers back to their
//     defaults, header search at position zero, both streams armed, banks zero
// ----------------------------------------------------------------------------
`default_nettype none

module image_stream_deframer
    import isd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // data_byte
    input  wire logic [0:0]           s_tuser,   // action
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // write_bank, pixel_row[11], byte_column[13], pixel_byte[8], pair_ready,
    // pair_color_bank, pair_depth_bank, frame_lost, zero fill[3]
    output logic [39:0]               m_tdata,
    output logic [2:0]                m_tuser,   // write_valid, stream_kind[2]
    output logic                      m_tlast    // frame_end
);

    cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;
    logic res_valid;
    res_t res;

    // config registers live in the parser and take every write
    assign cfg_ready = 1'b1;

    isd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_action (s_tuser[0]),
        .in_data   (s_tdata),
        .in_ready  (s_tready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    isd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_cmd   (f_cmd),
        .push_ready (f_ready),
        .pop_valid  (q_valid),
        .pop_cmd    (q_cmd),
        .pop_ready  (q_ready)
    );

    isd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_ready (q_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (m_tready)
    );

    // result beat packing, lowest field first
    assign m_tvalid = res_valid;
    assign m_tlast  = res.frame_end;
    assign m_tuser  = {res.stream_kind, res.write_valid};
    assign m_tdata  = {3'b000,
                       res.frame_lost,
                       res.pair_depth_bank,
                       res.pair_color_bank,
                       res.pair_ready,
                       res.pixel_byte,
                       res.byte_column,
                       res.pixel_row,
                       res.write_bank};

    // a pair event only comes with the end of a frame
    a_pair_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33] || m_tdata[36]) |-> m_tlast)
        else $error("pair or lost event without frame end");

    // matched pair and lost frame exclude each other
    a_pair_xor_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[33] && m_tdata[36]))
        else $error("pair ready and frame lost together");

    // a beat without payload is a zero length frame end with cleared position
    a_empty_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[32:1] == 32'd0))
        else $error("non-payload beat is not a clean empty frame end");

    // infrared frames never report pairing
    a_ir_no_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:1] == KIND_INFRARED) |->
            !m_tdata[33] && !m_tdata[36] && !m_tdata[0])
        else $error("infrared beat with pair event or bank one");

endmodule

`default_nettype wire

/* sim/image_stream_deframer_test.sv */
// ----------------------------------------------------------------------------
// image_stream_deframer_test: self-checking bench for the image stream deframer
// feeds header, payload and release beats with random gaps on both streams,
// mirrors header parsing, row/column tagging and color/depth pairing in a
// local model, and compares every result beat field by field in order
// ----------------------------------------------------------------------------
`default_nettype none

module image_stream_deframer_test;
    import isd_pkg::*;

    localparam int STALL_LIMIT  = 1000;  // cycles without any accepted beat
    localparam int DRAIN_CYCLES = 6;     // header beats may still be in flight
    localparam int END_CYCLES   = 20;
    localparam int RANDOM_BEATS = 120;

    // header byte positions
    localparam int unsigned HDR_SIG0 = 0;
    localparam int unsigned HDR_TYPE = 1;
    localparam int unsigned HDR_SIG1 = 2;
    localparam int unsigned HDR_FNUM = 3;
    localparam int unsigned HDR_LEN3 = 7;

    localparam logic [7:0] DEF_SIGNATURE = 8'hAA;
    localparam logic [7:0] DEF_COLOR     = 8'h01;
    localparam logic [7:0] DEF_DEPTH     = 8'h02;
    localparam logic [7:0] DEF_INFRARED  = 8'h03;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;   // data_byte
    logic [0:0]           s_tuser   = '0;   // action
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // write_bank, pixel_row[11], byte_column[13], pixel_byte[8], pair_ready,
    // pair_color_bank, pair_depth_bank, frame_lost, zero fill[3]
    logic [39:0]          m_tdata;
    logic [2:0]           m_tuser;          // write_valid, stream_kind[2]
    logic                 m_tlast;          // frame_end

    always #4 aclk = ~aclk;

    image_stream_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // register mirror
    logic [7:0] sig_code   = DEF_SIGNATURE;
    logic [7:0] color_code = DEF_COLOR;
    logic [7:0] depth_code = DEF_DEPTH;
    logic [7:0] ir_code    = DEF_INFRARED;

    // deframer model state
    int unsigned hdr_pos   = HDR_SIG0;
    logic        in_frame  = 1'b0;
    kind_t       cur_kind  = KIND_COLOR;
    logic        cur_bank  = 1'b0;
    logic [31:0] remaining = '0;
    int unsigned row = 0, col = 0;
    logic c_fill = 1'b0, d_fill = 1'b0, c_read = 1'b0, d_read = 1'b0;
    logic c_armed = 1'b1, d_armed = 1'b1;
    logic [7:0] c_fnum = '0, d_fnum = '0, ir_fnum = '0;

    res_t writes_due [$];

    int errors = 0, beats_in = 0, results_seen = 0;
    int frames_closed = 0, pairs_matched = 0, frames_lost = 0;
    bit idle_on = 1'b1;
    int tx_gap = 0;
    int rx_hold = 0, rx_draw = 0;
    int quiet_cycles = 0;

    // frame end bookkeeping: flip the fill bank once per armed stream, then pair
    function automatic void close_frame(inout res_t r);
        in_frame = 1'b0;
        r.frame_end = 1'b1;
        frames_closed++;
        if (cur_kind == KIND_COLOR) begin
            if (!c_armed) return;
            c_fill  = ~c_fill;
            c_armed = 1'b0;
        end else if (cur_kind == KIND_DEPTH) begin
            if (!d_armed) return;
            d_fill  = ~d_fill;
            d_armed = 1'b0;
        end else begin
            return;
        end
        if (!c_armed && !d_armed) begin
            if (c_fnum == d_fnum) begin
                r.pair_ready      = 1'b1;
                r.pair_color_bank = c_read;
                r.pair_depth_bank = d_read;
                pairs_matched++;
            end else begin
                // the older stream gets its frame slot back
                r.frame_lost = 1'b1;
                frames_lost++;
                if (c_fnum > d_fnum) begin
                    d_fill  = d_read;
                    d_armed = 1'b1;
                end else begin
                    c_fill  = c_read;
                    c_armed = 1'b1;
                end
            end
        end
    endfunction

    // advance the model by one accepted input beat
    function automatic void deframe_beat(input logic act, input logic [7:0] b);
        res_t        r;
        logic        ok;
        int unsigned rows, cols;
        r = '0;
        if (act == ACT_RELEASE) begin
            c_read  = ~c_read;
            d_read  = ~d_read;
            c_armed = 1'b1;
            d_armed = 1'b1;
            return;
        end
        if (in_frame) begin
            case (cur_kind)
                KIND_COLOR: begin rows = COLOR_ROWS; cols = COLOR_ROW_BYTES; end
                KIND_DEPTH: begin rows = DEPTH_ROWS; cols = DEPTH_ROW_BYTES; end
                default:    begin rows = INFRARED_ROWS; cols = INFRARED_ROW_BYTES; end
            endcase
            r.write_valid = 1'b1;
            r.stream_kind = cur_kind;
            r.write_bank  = cur_bank;
            r.pixel_row   = ROW_W'(row);
            r.byte_column = COL_W'(col);
            r.pixel_byte  = b;
            if (col + 1 >= cols) begin
                col = 0;
                row = (row + 1 >= rows) ? 0 : row + 1;
            end else begin
                col++;
            end
            remaining = remaining - 1;
            if (remaining == 0) close_frame(r);
            writes_due.insert(writes_due.size(), r);
            return;
        end
        ok = 1'b1;
        case (hdr_pos)
            HDR_SIG0, HDR_SIG1: ok = (b == sig_code);
            HDR_TYPE: begin
                // earlier stream wins when codes collide
                if (b == color_code) begin
                    cur_kind = KIND_COLOR;
                    cur_bank = c_fill;
                end else if (b == depth_code) begin
                    cur_kind = KIND_DEPTH;
                    cur_bank = d_fill;
                end else if (b == ir_code) begin
                    cur_kind = KIND_INFRARED;
                    cur_bank = 1'b0;
                end else begin
                    ok = 1'b0;
                end
            end
            HDR_FNUM: begin
                if (cur_kind == KIND_COLOR) c_fnum = b;
                else if (cur_kind == KIND_DEPTH) d_fnum = b;
                else ir_fnum = b;
            end
            4: remaining = {24'h0, b};
            5: remaining[15:8] = b;
            6: remaining[23:16] = b;
            default: remaining[31:24] = b;
        endcase
        if (!ok) begin
            hdr_pos = HDR_SIG0;
        end else if (hdr_pos < HDR_LEN3) begin
            hdr_pos++;
        end else begin
            hdr_pos  = HDR_SIG0;
            row      = 0;
            col      = 0;
            in_frame = 1'b1;
            if (remaining == 0) begin
                // empty frame ends right at its header
                r.stream_kind = cur_kind;
                r.write_bank  = cur_bank;
                close_frame(r);
                writes_due.insert(writes_due.size(), r);
            end
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_beat();
        res_t got, want;
        got.write_valid     = m_tuser[0];
        got.stream_kind     = kind_t'(m_tuser[2:1]);
        got.write_bank      = m_tdata[0];
        got.pixel_row       = m_tdata[11:1];
        got.byte_column     = m_tdata[24:12];
        got.pixel_byte      = m_tdata[32:25];
        got.frame_end       = m_tlast;
        got.pair_ready      = m_tdata[33];
        got.pair_color_bank = m_tdata[34];
        got.pair_depth_bank = m_tdata[35];
        got.frame_lost      = m_tdata[36];
        results_seen++;
        if (writes_due.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h/%h/%b",
                     $time, m_tdata, m_tuser, m_tlast);
            errors++;
            return;
        end
        want = writes_due.pop_front();
        cmp_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
        cmp_field("stream_kind", 32'(want.stream_kind), 32'(got.stream_kind));
        cmp_field("write_bank", 32'(want.write_bank), 32'(got.write_bank));
        cmp_field("pixel_row", 32'(want.pixel_row), 32'(got.pixel_row));
        cmp_field("byte_column", 32'(want.byte_column), 32'(got.byte_column));
        cmp_field("pixel_byte", 32'(want.pixel_byte), 32'(got.pixel_byte));
        cmp_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
        cmp_field("pair_ready", 32'(want.pair_ready), 32'(got.pair_ready));
        cmp_field("pair_color_bank", 32'(want.pair_color_bank), 32'(got.pair_color_bank));
        cmp_field("pair_depth_bank", 32'(want.pair_depth_bank), 32'(got.pair_depth_bank));
        cmp_field("frame_lost", 32'(want.frame_lost), 32'(got.frame_lost));
        cmp_field("zero fill", 32'd0, 32'(m_tdata[39:37]));
    endfunction

    // result side: random hold-off after each beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid === 1'b1 && m_tready) begin
            check_beat();
            rx_draw = idle_on ? $urandom_range(0, 19) : 0;
            rx_hold  <= rx_draw;
            m_tready <= (rx_draw == 0);
        end else if (rx_hold != 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog on handshake progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)
                || (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no beat accepted for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat; tvalid stays up when the next beat follows at once
    task automatic send_beat(input logic act, input logic [7:0] b);
        repeat (tx_gap) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (s_tready !== 1'b1);
        beats_in++;
        deframe_beat(act, b);
        tx_gap = idle_on ? $urandom_range(0, 19) : 0;
        if (tx_gap != 0) s_tvalid <= 1'b0;
    endtask

    task automatic tx_stop();
        if (tx_gap == 0) s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        tx_stop();
        while (writes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_registers(input logic [7:0] sig, input logic [7:0] c,
                                  input logic [7:0] d, input logic [7:0] ir);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [7:0]           val [4];
        idx = '{REG_SIGNATURE, REG_COLOR_CODE, REG_DEPTH_CODE, REG_INFRARED_CODE};
        val = '{sig, c, d, ir};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (cfg_ready !== 1'b1);
            case (idx[i])
                REG_SIGNATURE:  sig_code   = val[i];
                REG_COLOR_CODE: color_code = val[i];
                REG_DEPTH_CODE: depth_code = val[i];
                default:        ir_code    = val[i];
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_header(input logic [7:0] code, input logic [7:0] fnum,
                               input logic [31:0] len);
        send_beat(ACT_BYTE, sig_code);
        send_beat(ACT_BYTE, code);
        send_beat(ACT_BYTE, sig_code);
        send_beat(ACT_BYTE, fnum);
        for (int i = 0; i < 4; i++) send_beat(ACT_BYTE, len[8*i +: 8]);
    endtask

    // header plus random payload, with an occasional release mixed in
    task automatic send_frame(input logic [7:0] code, input logic [7:0] fnum,
                              input int unsigned len, input int release_pct);
        send_header(code, fnum, len);
        for (int unsigned i = 0; i < len; i++) begin
            if (release_pct != 0 && $urandom_range(0, 99) < release_pct)
                send_beat(ACT_RELEASE, 8'($urandom_range(0, 255)));
            send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    // any byte that cannot open a header
    function automatic logic [7:0] stray_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == sig_code);
        return b;
    endfunction

    task automatic test_frame_pairing();
        send_frame(color_code, 8'd5, 0, 0);
        send_header(depth_code, 8'd5, 2);
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_BYTE, 8'hFF);                 // matched pair
        send_beat(ACT_RELEASE, 8'hFF);
        send_frame(color_code, 8'd9, 1, 0);
        send_frame(depth_code, 8'd3, 0, 0);         // lost, depth older
        send_frame(depth_code, 8'd9, 1, 0);
        send_beat(ACT_RELEASE, 8'h00);
        send_frame(color_code, 8'd1, 0, 0);
        send_frame(color_code, 8'd1, 1, 0);         // color no longer armed
        send_frame(depth_code, 8'hFF, 0, 0);        // lost, color older
        send_header(color_code, 8'd2, 3);           // release in mid frame
        send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_beat(ACT_RELEASE, 8'($urandom_range(0, 255)));
        send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        send_frame(ir_code, 8'd7, 0, 0);
        send_frame(ir_code, 8'd8, 2, 0);
    endtask

    task automatic test_header_faults();
        send_beat(ACT_BYTE, ~sig_code);             // no signature
        send_beat(ACT_BYTE, sig_code);
        send_beat(ACT_BYTE, 8'h77);                 // unknown type
        send_beat(ACT_BYTE, sig_code);
        send_beat(ACT_BYTE, color_code);
        send_beat(ACT_BYTE, ~sig_code);             // bad second signature
        // a repeated signature is dropped, not taken as a new start
        send_beat(ACT_BYTE, sig_code);
        send_beat(ACT_BYTE, sig_code);
        send_beat(ACT_BYTE, depth_code);
        send_frame(depth_code, 8'd4, 3, 0);
    endtask

    task automatic test_register_settings();
        logic [7:0] code;
        for (int s = 0; s < 4; s++) begin
            wait_drained();
            case (s)
                0: load_registers(8'h00, 8'hFF, 8'h00, 8'h80);
                1: load_registers(8'hFF, 8'h07, 8'h07, 8'h07);   // color shadows all
                2: load_registers(8'h5A, 8'h10, 8'h20, 8'h10);   // color shadows ir
                default: load_registers(DEF_SIGNATURE, DEF_COLOR, DEF_DEPTH, DEF_INFRARED);
            endcase
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 2))
                    0: code = color_code;
                    1: code = depth_code;
                    default: code = ir_code;
                endcase
                send_frame(code, 8'($urandom_range(0, 1)), $urandom_range(0, 4), 0);
            end
            send_beat(ACT_RELEASE, 8'($urandom_range(0, 255)));
        end
    endtask

    // column wrap and row step on infrared; no idling here
    task automatic test_row_column_wrap();
        idle_on = 1'b0;
        send_frame(ir_code, 8'h11, INFRARED_ROW_BYTES + 2, 0);
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned goal, pick, len;
        logic [7:0]  code, fnum;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                wait_drained();
                load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else if (phase == 2) begin
                wait_drained();
                load_registers(DEF_SIGNATURE, DEF_COLOR, DEF_DEPTH, DEF_INFRARED);
            end
            goal = beats_in + RANDOM_BEATS / 3;
            while (beats_in < goal) begin
                if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
                pick = $urandom_range(0, 9);
                if (pick <= 6) begin
                    case ($urandom_range(0, 2))
                        0: code = color_code;
                        1: code = depth_code;
                        default: code = ir_code;
                    endcase
                    // few frame numbers so that pairs often match
                    fnum = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                       : 8'($urandom_range(0, 2));
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(0, 12);
                    send_frame(code, fnum, len, 5);
                end else if (pick == 7) begin
                    send_beat(ACT_RELEASE, 8'($urandom_range(0, 255)));
                end else if (pick == 8) begin
                    repeat ($urandom_range(1, 6)) send_beat(ACT_BYTE, stray_byte());
                end else begin
                    // header cut short, then back in sync
                    send_beat(ACT_BYTE, sig_code);
                    if ($urandom_range(0, 1) == 1)
                        send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
                    send_beat(ACT_BYTE, stray_byte());
                    while (hdr_pos != HDR_SIG0) send_beat(ACT_BYTE, stray_byte());
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // huge declared length; the run ends inside this frame
    task automatic test_long_length();
        send_header(color_code, 8'h3C, 32'hFF80_7F01);
        repeat (12) begin
            if ($urandom_range(0, 9) == 0)
                send_beat(ACT_RELEASE, 8'($urandom_range(0, 255)));
            send_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_frame_pairing();
        test_header_faults();
        test_register_settings();
        test_row_column_wrap();
        test_random_traffic();
        test_long_length();
        tx_stop();
        while (writes_due.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        $display("run covered %0d input beats and %0d result beats, %0d frames closed",
                 beats_in, results_seen, frames_closed);
        $display("pairing saw %0d matched pairs and %0d lost frames", pairs_matched,
                 frames_lost);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
